### sv/ptc_pkg.sv
// shared types and constants for the pressure / temperature compensation pipeline
// no dependencies

package ptc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } t_in;

    typedef struct packed {
        logic signed [12:0] temperature_tenths;
        logic [17:0]        pressure_pa;
        logic [1:0]         status;
    } t_out;

    // sideband carried through the temperature divider
    typedef struct packed {
        logic signed [31:0] x1;
        logic [18:0]        up;
        logic               neg;
        logic               zero;
    } t_side_t;

    // sideband carried through the pressure divider
    typedef struct packed {
        logic signed [12:0] t;
        logic               tsat;
        logic               zero;
        logic               shift;
    } t_side_p;

    localparam logic [2:0] CFG_OSS   = 3'd0;
    localparam logic [2:0] CFG_AC123 = 3'd1;
    localparam logic [2:0] CFG_AC456 = 3'd2;
    localparam logic [2:0] CFG_B12   = 3'd3;
    localparam logic [2:0] CFG_MCMD  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [1:0]         OSS_RESET  = 2'd3;
    localparam logic signed [31:0] TEMP_MIN   = -32'sd4096;
    localparam logic signed [31:0] TEMP_MAX   = 32'sd4095;
    localparam logic signed [31:0] PRES_MAX   = 32'sd262143;
    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic signed [31:0] X3_OFFSET  = 32'sd32768;
    localparam logic [16:0]        PRES_SCALE = 17'd50000;
    localparam logic signed [31:0] P_C1       = 32'sd3038;
    localparam logic signed [31:0] P_C2       = -32'sd7357;
    localparam logic signed [31:0] P_C3       = 32'sd3791;

endpackage

### sv/ptc_udiv.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// carries an opaque sideband word alongside; no package dependency

module ptc_udiv #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_valid [NW];
    logic [NW-1:0] r_num   [NW];
    logic [DW-1:0] r_den   [NW];
    logic [DW-1:0] r_rem   [NW];
    logic [NW-1:0] r_quo   [NW];
    logic [SW-1:0] r_side  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          w_valid;
        logic [NW-1:0] w_num;
        logic [DW-1:0] w_den;
        logic [DW-1:0] w_rem;
        logic [NW-1:0] w_quo;
        logic [SW-1:0] w_side;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_num   = i_num;
            assign w_den   = i_den;
            assign w_rem   = '0;
            assign w_quo   = '0;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_num   = r_num[k-1];
            assign w_den   = r_den[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_quo   = r_quo[k-1];
            assign w_side  = r_side[k-1];
        end

        always_comb begin
            w_trial = {w_rem, w_num[NW-1-k]};
            w_diff  = w_trial - {1'b0, w_den};
            w_ge    = (w_trial >= {1'b0, w_den});
            n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_quo   = w_quo;
            n_quo[NW-1-k] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid;
            end
            r_num[k]  <= w_num;
            r_den[k]  <= w_den;
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_side[k] <= w_side;
        end
    end

    assign o_valid = r_valid[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

### sv/pressure_temperature_compensation_unit.sv
// top level: calibration registers and the compensation pipeline
// depends on ptc_pkg and ptc_udiv

// Takes one raw temperature / raw pressure word per cycle (o_busy is always low)
// and returns the compensated temperature in 0.1 C and pressure in Pa, with a
// status of ok, division by zero or saturated. Every word comes out in order as a
// one-cycle o_valid strobe; the receiver cannot stall, so it must take every
// result. The pipeline is two bit-per-stage dividers (27 and 32 stages) plus
// eleven arithmetic stages. Calibration is written through the cfg channel,
// which is always ready; write it only while no word is in flight.

module pressure_temperature_compensation_unit
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in         i_item,
    output logic        o_valid,
    output t_out        o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic [1:0]  r_oss;
    logic [47:0] r_ac123;
    logic [47:0] r_ac456;
    logic [31:0] r_b12;
    logic [31:0] r_mcmd;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss   <= OSS_RESET;
            r_ac123 <= '0;
            r_ac456 <= '0;
            r_b12   <= '0;
            r_mcmd  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OSS:   r_oss   <= i_cfg_data[1:0];
                CFG_AC123: r_ac123 <= i_cfg_data;
                CFG_AC456: r_ac456 <= i_cfg_data;
                CFG_B12:   r_b12   <= i_cfg_data[31:0];
                CFG_MCMD:  r_mcmd  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // calibration words, signed ones extended to 32 bits
    logic signed [31:0] ac1, ac2, ac3, b1, b2, md;
    logic [15:0] ac4, ac5, ac6, mc;
    assign ac1 = 32'($signed(r_ac123[15:0]));
    assign ac2 = 32'($signed(r_ac123[31:16]));
    assign ac3 = 32'($signed(r_ac123[47:32]));
    assign ac4 = r_ac456[15:0];
    assign ac5 = r_ac456[31:16];
    assign ac6 = r_ac456[47:32];
    assign b1  = 32'($signed(r_b12[15:0]));
    assign b2  = 32'($signed(r_b12[31:16]));
    assign mc  = r_mcmd[15:0];
    assign md  = 32'($signed(r_mcmd[31:16]));

    // stage 1: x1 = (ut - ac6) * ac5 >> 15
    logic signed [16:0] s1_d;
    logic signed [33:0] s1_p;
    logic signed [31:0] s1_w;
    logic               r1_v;
    logic signed [31:0] r1_x1;
    logic [18:0]        r1_up;

    always_comb begin
        s1_d = $signed({1'b0, i_item.raw_temperature}) - $signed({1'b0, ac6});
        s1_p = 34'(s1_d) * 34'($signed({1'b0, ac5}));
        s1_w = s1_p[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start && !o_busy;
        end
        r1_x1 <= s1_w >>> 15;
        r1_up <= i_item.raw_pressure;
    end

    // temperature division by magnitudes, sign fixed afterwards
    logic signed [31:0] s2_den;
    logic signed [26:0] s2_num;
    logic [26:0]        s2_nmag;
    logic [31:0]        s2_dmag;
    t_side_t            s2_side;
    logic               d1_v;
    logic [26:0]        d1_q;
    logic [$bits(t_side_t)-1:0] d1_sbits;
    t_side_t            d1_side;

    always_comb begin
        s2_den  = r1_x1 + md;
        s2_num  = {mc, 11'b0};
        s2_nmag = s2_num[26] ? 27'(-s2_num) : 27'(s2_num);
        s2_dmag = s2_den[31] ? 32'(-s2_den) : 32'(s2_den);
        s2_side.x1   = r1_x1;
        s2_side.up   = r1_up;
        s2_side.neg  = s2_num[26] ^ s2_den[31];
        s2_side.zero = (s2_den == 32'sd0);
        if (s2_side.zero) begin
            s2_dmag = 32'd1;
        end
    end

    ptc_udiv #(.NW(27), .DW(32), .SW($bits(t_side_t))) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_num   (s2_nmag),
        .i_den   (s2_dmag),
        .i_side  (s2_side),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_sbits)
    );
    assign d1_side = d1_sbits;

    // stage 3: b5 = x1 + x2
    logic signed [31:0] s3_x2;
    logic               r3_v;
    logic signed [31:0] r3_b5;
    logic [18:0]        r3_up;
    logic               r3_zero;

    assign s3_x2 = d1_side.neg ? -$signed({5'b0, d1_q}) : $signed({5'b0, d1_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= d1_v;
        end
        r3_b5   <= d1_side.x1 + s3_x2;
        r3_up   <= d1_side.up;
        r3_zero <= d1_side.zero;
    end

    // stage 4: temperature and b6
    logic signed [31:0] s4_t;
    logic               r4_v;
    logic signed [12:0] r4_t;
    logic               r4_tsat;
    logic signed [31:0] r4_b6;
    logic [18:0]        r4_up;
    logic               r4_zero;

    assign s4_t = (r3_b5 + 32'sd8) >>> 4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        if (s4_t < TEMP_MIN) begin
            r4_t    <= TEMP_MIN[12:0];
            r4_tsat <= 1'b1;
        end else if (s4_t > TEMP_MAX) begin
            r4_t    <= TEMP_MAX[12:0];
            r4_tsat <= 1'b1;
        end else begin
            r4_t    <= s4_t[12:0];
            r4_tsat <= 1'b0;
        end
        r4_b6   <= r3_b5 - B6_OFFSET;
        r4_up   <= r3_up;
        r4_zero <= r3_zero;
    end

    // stage 5: products with b6
    logic signed [31:0] s5_sq, s5_a2, s5_a3;
    logic               r5_v;
    logic signed [31:0] r5_b6sq, r5_x2a, r5_x1c;
    logic signed [12:0] r5_t;
    logic               r5_tsat, r5_zero;
    logic [18:0]        r5_up;

    always_comb begin
        s5_sq = r4_b6 * r4_b6;
        s5_a2 = ac2 * r4_b6;
        s5_a3 = ac3 * r4_b6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_b6sq <= s5_sq >>> 12;
        r5_x2a  <= s5_a2 >>> 11;
        r5_x1c  <= s5_a3 >>> 13;
        r5_t    <= r4_t;
        r5_tsat <= r4_tsat;
        r5_zero <= r4_zero;
        r5_up   <= r4_up;
    end

    // stage 6: products with b6 squared
    logic signed [31:0] s6_m2, s6_m1;
    logic               r6_v;
    logic signed [31:0] r6_x1b, r6_x2a, r6_x1c, r6_x2c;
    logic signed [12:0] r6_t;
    logic               r6_tsat, r6_zero;
    logic [18:0]        r6_up;

    always_comb begin
        s6_m2 = b2 * r5_b6sq;
        s6_m1 = b1 * r5_b6sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_x1b  <= s6_m2 >>> 11;
        r6_x2c  <= s6_m1 >>> 16;
        r6_x2a  <= r5_x2a;
        r6_x1c  <= r5_x1c;
        r6_t    <= r5_t;
        r6_tsat <= r5_tsat;
        r6_zero <= r5_zero;
        r6_up   <= r5_up;
    end

    // stage 7: b3 and the x3 term for b4
    logic signed [31:0] s7_a, s7_tmp, s7_b3;
    logic               r7_v;
    logic signed [31:0] r7_b3, r7_x3;
    logic signed [12:0] r7_t;
    logic               r7_tsat, r7_zero;
    logic [18:0]        r7_up;

    always_comb begin
        s7_a   = (ac1 <<< 2) + r6_x1b + r6_x2a;
        s7_tmp = (s7_a <<< r_oss) + 32'sd2;
        // truncating divide by four
        s7_b3  = (s7_tmp + (s7_tmp[31] ? 32'sd3 : 32'sd0)) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_b3   <= s7_b3;
        r7_x3   <= (r6_x1c + r6_x2c + 32'sd2) >>> 2;
        r7_t    <= r6_t;
        r7_tsat <= r6_tsat;
        r7_zero <= r6_zero;
        r7_up   <= r6_up;
    end

    // stage 8: b4 and b7
    logic [31:0]        s8_b4p, s8_diff, s8_b7;
    logic [16:0]        s8_scale;
    logic               r8_v;
    logic [31:0]        r8_b4, r8_b7;
    logic signed [12:0] r8_t;
    logic               r8_tsat, r8_zero;

    always_comb begin
        s8_b4p   = {16'b0, ac4} * 32'(r7_x3 + X3_OFFSET);
        s8_scale = PRES_SCALE >> r_oss;
        s8_diff  = {13'b0, r7_up} - 32'(r7_b3);
        s8_b7    = s8_diff * {15'b0, s8_scale};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
        r8_b4   <= s8_b4p >> 15;
        r8_b7   <= s8_b7;
        r8_t    <= r7_t;
        r8_tsat <= r7_tsat;
        r8_zero <= r7_zero;
    end

    // pressure division
    logic [31:0] s9_num, s9_den;
    t_side_p     s9_side;
    logic        d2_v;
    logic [31:0] d2_q;
    logic [$bits(t_side_p)-1:0] d2_sbits;
    t_side_p     d2_side;

    always_comb begin
        s9_side.t     = r8_t;
        s9_side.tsat  = r8_tsat;
        s9_side.zero  = r8_zero || (r8_b4 == 32'd0);
        s9_side.shift = r8_b7[31];
        s9_num = r8_b7[31] ? r8_b7 : {r8_b7[30:0], 1'b0};
        s9_den = (r8_b4 == 32'd0) ? 32'd1 : r8_b4;
    end

    ptc_udiv #(.NW(32), .DW(32), .SW($bits(t_side_p))) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r8_v),
        .i_num   (s9_num),
        .i_den   (s9_den),
        .i_side  (s9_side),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_sbits)
    );
    assign d2_side = d2_sbits;

    // stage 10: pressure estimate
    logic               r10_v;
    logic signed [31:0] r10_p;
    t_side_p            r10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else begin
            r10_v <= d2_v;
        end
        r10_p    <= d2_side.shift ? {d2_q[30:0], 1'b0} : d2_q;
        r10_side <= d2_side;
    end

    // stage 11: square term and linear term
    logic signed [31:0] s11_s, s11_sq, s11_lin;
    logic               r11_v;
    logic signed [31:0] r11_p, r11_sq, r11_x2;
    t_side_p            r11_side;

    always_comb begin
        s11_s   = r10_p >>> 8;
        s11_sq  = s11_s * s11_s;
        s11_lin = P_C2 * r10_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else begin
            r11_v <= r10_v;
        end
        r11_p    <= r10_p;
        r11_sq   <= s11_sq;
        r11_x2   <= s11_lin >>> 16;
        r11_side <= r10_side;
    end

    // stage 12: scale the square term
    logic signed [31:0] s12_m;
    logic               r12_v;
    logic signed [31:0] r12_p, r12_x1, r12_x2;
    t_side_p            r12_side;

    assign s12_m = r11_sq * P_C1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else begin
            r12_v <= r11_v;
        end
        r12_p    <= r11_p;
        r12_x1   <= s12_m >>> 16;
        r12_x2   <= r11_x2;
        r12_side <= r11_side;
    end

    // output stage: final pressure, saturation and status
    logic signed [31:0] s13_pr;
    logic               s13_psat;
    logic [17:0]        s13_pa;
    t_out               n_result;

    always_comb begin
        s13_pr   = r12_p + ((r12_x1 + r12_x2 + P_C3) >>> 4);
        s13_psat = 1'b0;
        s13_pa   = s13_pr[17:0];
        if (s13_pr < 32'sd0) begin
            s13_pa   = '0;
            s13_psat = 1'b1;
        end else if (s13_pr > PRES_MAX) begin
            s13_pa   = PRES_MAX[17:0];
            s13_psat = 1'b1;
        end
        if (r12_side.zero) begin
            n_result.temperature_tenths = '0;
            n_result.pressure_pa        = '0;
            n_result.status             = ST_DIV0;
        end else begin
            n_result.temperature_tenths = r12_side.t;
            n_result.pressure_pa        = s13_pa;
            n_result.status = (r12_side.tsat || s13_psat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r12_v;
        end
        o_result <= n_result;
    end

endmodule

### sim/tb_top.sv
// testbench for pressure_temperature_compensation_unit: directed table then random pairs
// predicts each result not given in a directed row with a local integer model of the compensation formulas
// depends on ptc_pkg and the unit's rtl

`timescale 1ns / 100ps

module tb_top;
    import ptc_pkg::*;

    // register index past the end of the list, writes to it are ignored
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_in         i_item = '0;
    logic        o_valid;
    t_out        o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    pressure_temperature_compensation_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // local copy of the calibration
    logic [1:0]  oss_q;
    logic [47:0] ac123_q, ac456_q;
    logic [31:0] b12_q, mcmd_q;

    t_out        pending_words[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          stall_free = 1'b0;

    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
        bit          known;
        t_out        want;
    } t_row;

    function automatic logic [31:0] sar(logic [31:0] v, int n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
        return $unsigned($signed(a) / $signed(b));
    endfunction

    function automatic logic [31:0] sx(logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic t_out compensate(logic [15:0] ut, logic [18:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b5, b6, b6sq, b3, b4, b7, p, den;
        logic signed [31:0] t, pr;
        t_out r;
        ac1 = sx(ac123_q[15:0]);  ac2 = sx(ac123_q[31:16]); ac3 = sx(ac123_q[47:32]);
        ac4 = ac456_q[15:0];      ac5 = ac456_q[31:16];     ac6 = ac456_q[47:32];
        b1 = sx(b12_q[15:0]);     b2 = sx(b12_q[31:16]);
        mc = sx(mcmd_q[15:0]);    md = sx(mcmd_q[31:16]);
        r = '0;
        r.status = ST_DIV0;
        x1 = sar((32'(ut) - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv(mc * 32'd2048, den);
        b5 = x1 + x2;
        t = $signed(sar(b5 + 32'd8, 4));
        b6 = b5 - 32'd4000;
        b6sq = sar(b6 * b6, 12);
        x1 = sar(b2 * b6sq, 11);
        x2 = sar(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = ((ac1 * 32'd4 + x3) << oss_q) + 32'd2;
        b3 = sdiv(b3, 32'd4);
        x1 = sar(ac3 * b6, 13);
        x2 = sar(b1 * b6sq, 16);
        x3 = sar(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (32'(up) - b3) * (32'd50000 >> oss_q);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sar(p, 8) * sar(p, 8);
        x1 = sar(x1 * 32'd3038, 16);
        x2 = sar((32'd0 - 32'd7357) * p, 16);
        pr = $signed(p + sar(x1 + x2 + 32'd3791, 4));
        r.status = ST_OK;
        if (t < TEMP_MIN) begin t = TEMP_MIN; r.status = ST_SAT; end
        if (t > TEMP_MAX) begin t = TEMP_MAX; r.status = ST_SAT; end
        if (pr < 0) begin pr = 0; r.status = ST_SAT; end
        if (pr > PRES_MAX) begin pr = PRES_MAX; r.status = ST_SAT; end
        r.temperature_tenths = t[12:0];
        r.pressure_pa = pr[17:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_result);
            end else begin
                t_out w;
                w = pending_words.pop_front();
                if (w.temperature_tenths !== o_result.temperature_tenths ||
                    w.pressure_pa !== o_result.pressure_pa || w.status !== o_result.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want t=%0d p=%0d s=%0d got t=%0d p=%0d s=%0d",
                                 w.temperature_tenths, w.pressure_pa, w.status,
                                 o_result.temperature_tenths, o_result.pressure_pa,
                                 o_result.status);
                end
            end
        end
    end

    // one write, then i_cfg_valid drops low so back to back writes never collide
    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OSS:   oss_q   = val[1:0];
            CFG_AC123: ac123_q = val;
            CFG_AC456: ac456_q = val;
            CFG_B12:   b12_q   = val[31:0];
            CFG_MCMD:  mcmd_q  = val[31:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // send one pair, idling at random first unless stall_free is set
    task automatic send_pair(logic [15:0] ut, logic [18:0] up, bit known, t_out want);
        while (!stall_free && $urandom_range(99) < 37) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= '{raw_temperature: ut, raw_pressure: up};
        do @(posedge i_clk); while (o_busy);
        pending_words.push_back(known ? want : compensate(ut, up));
    endtask

    task automatic drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_cal(bit typical);
        if (typical) begin
            write_reg(CFG_AC123, {16'hC7A2, 16'hFBE5, 16'h1BF8});  // ac3 ac2 ac1
            write_reg(CFG_AC456, {16'h4A27, 16'h6268, 16'h84B2});  // ac6 ac5 ac4
            write_reg(CFG_B12, {16'h0000, 16'h002B, 16'h157A});
            write_reg(CFG_MCMD, {16'h0000, 16'h0B48, 16'hD4BD});
        end else begin
            write_reg(CFG_AC123, 48'({$urandom(), $urandom()}));
            write_reg(CFG_AC456, 48'({$urandom(), $urandom()}));
            write_reg(CFG_B12, {16'h0000, $urandom()});
            write_reg(CFG_MCMD, {16'h0000, $urandom()});
        end
    endtask

    function automatic t_out word_of(logic signed [12:0] t, logic [17:0] p, logic [1:0] s);
        t_out r;
        r.temperature_tenths = t;
        r.pressure_pa = p;
        r.status = s;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_out none;
        none = '0;
        oss_q = OSS_RESET; ac123_q = '0; ac456_q = '0; b12_q = '0; mcmd_q = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // calibration all zero after reset: md and x1 zero, so divide by zero
        rows.push_back('{16'h0000, 19'h00000, 1'b1, word_of(13'sd0, 18'd0, ST_DIV0)});
        rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b1, word_of(13'sd0, 18'd0, ST_DIV0)});
        foreach (rows[i]) send_pair(rows[i].ut, rows[i].up, rows[i].known, rows[i].want);
        drain();

        // md only, ac4 zero: b4 zero gives divide by zero
        write_reg(CFG_MCMD, {16'h0000, 16'h0001, 16'h0000});
        send_pair(16'h1234, 19'h00100, 1'b1, word_of(13'sd0, 18'd0, ST_DIV0));
        drain();

        rows.delete();
        write_reg(CFG_OSS, 48'd0);
        load_cal(1'b1);
        rows.push_back('{16'h0000, 19'h00000, 1'b0, none});
        rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, none});
        rows.push_back('{16'h6C50, 19'h05D23, 1'b0, none});
        rows.push_back('{16'h8000, 19'h40000, 1'b0, none});
        rows.push_back('{16'h7FFF, 19'h3FFFF, 1'b0, none});
        rows.push_back('{16'h0001, 19'h00001, 1'b0, none});
        rows.push_back('{16'h4A27, 19'h0FFFF, 1'b0, none});
        foreach (rows[i]) send_pair(rows[i].ut, rows[i].up, rows[i].known, rows[i].want);
        drain();
        write_reg(CFG_OSS, 48'd3);
        foreach (rows[i]) send_pair(rows[i].ut, rows[i].up, rows[i].known, rows[i].want);
        drain();
        // extremes of calibration words
        write_reg(CFG_AC123, 48'h8000_7FFF_8000);
        write_reg(CFG_AC456, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_B12, 48'h0000_7FFF_8000);
        write_reg(CFG_MCMD, 48'h0000_8000_7FFF);
        foreach (rows[i]) send_pair(rows[i].ut, rows[i].up, rows[i].known, rows[i].want);
        drain();

        // random phases, mostly realistic calibration near the typical readings
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(CFG_OSS, 48'($urandom_range(3)));
            load_cal(ph % 3 != 2);
            if (ph % 5 == 4) write_reg(CFG_UNUSED, 48'({$urandom(), $urandom()}));
            stall_free = (ph == 6);
            for (int k = 0; k < 100; k++) begin
                logic [15:0] ut;
                logic [18:0] up;
                if ($urandom_range(3) != 0) begin
                    ut = 16'($urandom_range(22000, 33000));
                    up = 19'($urandom_range(15000, 45000) << oss_q) | 19'($urandom_range(7));
                end else begin
                    ut = 16'($urandom());
                    up = 19'($urandom());
                end
                send_pair(ut, up, 1'b0, none);
            end
            stall_free = 1'b0;
            drain();
        end

        if (mismatches == 0 && pending_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
